// ===== rtl/srg_pkg.sv =====
// Shared types and constants of the subtractive random generator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package srg_pkg;

  // Lag table geometry.
  localparam int IDX_W       = 6;
  localparam int TABLE_DEPTH = 55;
  localparam int LAST_IDX    = TABLE_DEPTH - 1;
  localparam int LAG_SHORT   = 24;
  localparam int LAG_GAP     = 31;

  // Warm-up scatter: entry (SCATTER_STEP * j) mod SCATTER_MOD, j = 1..SCATTER_MOD.
  localparam int SCATTER_STEP = 21;
  localparam int SCATTER_MOD  = 54;

  // Number of full table advances after the scatter.
  localparam int ADV_PASSES = 3;

  // Fixed field widths.
  localparam int THR_W  = 33;
  localparam int SEED_W = 32;
  localparam int FRAC_W = 32;

  // Width of one multiplier chunk of the range span.
  localparam int MUL_W = 17;

  // Request commands.
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             take_in;     // latch the request payload
    logic             reseed;      // clear the table, load warm-up values
    logic             scatter;     // write warm-up value, step the recurrence
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] addr_a;      // entry being updated or drawn
    logic [IDX_W-1:0] addr_b;      // its lag partner
    logic             load_entry;
    logic             entry_diff;  // drawn entry is the freshly advanced value
    logic             mul_start;
    logic             mul_step;
    logic             out_load;
  } srg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_last;
    logic out_free;
  } srg_stat_t;

  // Lag partner of entry j within one table advance.
  function automatic logic [IDX_W-1:0] lag_partner(input logic [IDX_W-1:0] j);
    logic [IDX_W-1:0] p;
    if (j < IDX_W'(LAG_SHORT)) begin
      p = j + IDX_W'(LAG_GAP);
    end else begin
      p = j - IDX_W'(LAG_SHORT);
    end
    return p;
  endfunction

endpackage

// ===== rtl/srg_if.sv =====
// Channel interfaces of the subtractive random generator: request,
// response and seed configuration. Depends on srg_pkg for field widths.
`timescale 1ns / 1ps

interface srg_req_if #(
  parameter int PICK_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [srg_pkg::THR_W-1:0]   threshold;
  logic [PICK_BITS-1:0]        range_low;
  logic [PICK_BITS-1:0]        range_high;

  modport source (output valid, cmd, threshold, range_low, range_high, input ready);
  modport sink   (input valid, cmd, threshold, range_low, range_high, output ready);
endinterface

interface srg_rsp_if #(
  parameter int PICK_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [srg_pkg::FRAC_W-1:0]  fraction;
  logic                        coin;
  logic [PICK_BITS-1:0]        pick;

  modport source (output valid, fraction, coin, pick, input ready);
  modport sink   (input valid, fraction, coin, pick, output ready);
endinterface

interface srg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [srg_pkg::SEED_W-1:0]  seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

// ===== rtl/srg_ctrl.sv =====
// Sequencer of the subtractive random generator: reseed scatter, table
// advances, lazy per-draw advance and the draw sequence. Depends on srg_pkg.
`timescale 1ns / 1ps

module srg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_cmd_i,
  output logic               req_ready_o,
  input  srg_pkg::srg_stat_t stat_i,
  output srg_pkg::srg_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCATTER,
    ST_ADV_RD,
    ST_ADV_WR,
    ST_DRAW_RD,
    ST_DRAW_EX,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e                    state_q;
  logic [srg_pkg::IDX_W-1:0] idx_q;    // read index
  logic                      lazy_q;   // table advance is spread over the draws
  logic                      wrap_q;   // single advance of entry zero before a draw
  logic [srg_pkg::IDX_W-1:0] j_q;      // scatter step or advance position
  logic [srg_pkg::IDX_W-1:0] ii_q;     // scatter target entry
  logic [1:0]                pass_q;

  logic                      accept;
  logic [srg_pkg::IDX_W-1:0] idx_inc;
  logic [srg_pkg::IDX_W:0]   ii_sum;
  logic [srg_pkg::IDX_W-1:0] ii_next;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign idx_inc     = idx_q + srg_pkg::IDX_W'(1);

  // Next scatter target, kept below the modulus by one compare and subtract.
  assign ii_sum  = {1'b0, ii_q} + (srg_pkg::IDX_W + 1)'(srg_pkg::SCATTER_STEP);
  assign ii_next = (ii_sum >= (srg_pkg::IDX_W + 1)'(srg_pkg::SCATTER_MOD))
                 ? srg_pkg::IDX_W'(ii_sum - (srg_pkg::IDX_W + 1)'(srg_pkg::SCATTER_MOD))
                 : srg_pkg::IDX_W'(ii_sum);

  // Commands decoded from the current state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.addr_a     = j_q;
    cmd_o.addr_b     = srg_pkg::lag_partner(j_q);
    cmd_o.wr_addr    = j_q;
    cmd_o.entry_diff = lazy_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take_in = accept;
        cmd_o.reseed  = accept && (req_cmd_i == srg_pkg::CMD_RESEED);
      end
      ST_SCATTER: begin
        cmd_o.scatter = 1'b1;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ii_q;
      end
      ST_ADV_RD: begin
      end
      ST_ADV_WR: begin
        cmd_o.wr_en = 1'b1;
      end
      ST_DRAW_RD: begin
        cmd_o.addr_a = idx_q;
        cmd_o.addr_b = srg_pkg::lag_partner(idx_q);
      end
      ST_DRAW_EX: begin
        cmd_o.wr_en      = lazy_q;
        cmd_o.wr_addr    = idx_q;
        cmd_o.load_entry = 1'b1;
        cmd_o.mul_start  = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
      end
      ST_FIN: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      lazy_q  <= 1'b0;
      wrap_q  <= 1'b0;
      j_q     <= '0;
      ii_q    <= '0;
      pass_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (req_cmd_i == srg_pkg::CMD_RESEED) begin
              idx_q   <= '0;
              lazy_q  <= 1'b0;
              wrap_q  <= 1'b0;
              j_q     <= srg_pkg::IDX_W'(1);
              ii_q    <= srg_pkg::IDX_W'(srg_pkg::SCATTER_STEP);
              state_q <= ST_SCATTER;
            end else if (idx_inc >= srg_pkg::IDX_W'(srg_pkg::TABLE_DEPTH)) begin
              // Wrap: start a new lazy advance with entry zero.
              idx_q   <= srg_pkg::IDX_W'(1);
              lazy_q  <= 1'b1;
              wrap_q  <= 1'b1;
              j_q     <= '0;
              state_q <= ST_ADV_RD;
            end else begin
              idx_q   <= idx_inc;
              state_q <= ST_DRAW_RD;
            end
          end
        end
        ST_SCATTER: begin
          ii_q <= ii_next;
          if (j_q == srg_pkg::IDX_W'(srg_pkg::SCATTER_MOD)) begin
            j_q     <= '0;
            pass_q  <= '0;
            state_q <= ST_ADV_RD;
          end else begin
            j_q <= j_q + srg_pkg::IDX_W'(1);
          end
        end
        ST_ADV_RD: begin
          state_q <= ST_ADV_WR;
        end
        ST_ADV_WR: begin
          if (wrap_q) begin
            wrap_q  <= 1'b0;
            state_q <= ST_DRAW_RD;
          end else if (j_q == srg_pkg::IDX_W'(srg_pkg::LAST_IDX)) begin
            j_q <= '0;
            if (pass_q == 2'(srg_pkg::ADV_PASSES - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              pass_q  <= pass_q + 2'd1;
              state_q <= ST_ADV_RD;
            end
          end else begin
            j_q     <= j_q + srg_pkg::IDX_W'(1);
            state_q <= ST_ADV_RD;
          end
        end
        ST_DRAW_RD: begin
          state_q <= ST_DRAW_EX;
        end
        ST_DRAW_EX: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (stat_i.mul_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/srg_datapath.sv =====
// Datapath of the subtractive random generator: lag table memory, warm-up
// recurrence, chunked range multiplier and output register. Depends on srg_pkg.
`timescale 1ns / 1ps

module srg_datapath #(
  parameter int FRACTION_BITS = 32,
  parameter int PICK_BITS     = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srg_pkg::srg_cmd_t           cmd_i,
  output srg_pkg::srg_stat_t          stat_o,
  input  logic [srg_pkg::THR_W-1:0]   threshold_i,
  input  logic [PICK_BITS-1:0]        range_low_i,
  input  logic [PICK_BITS-1:0]        range_high_i,
  input  logic                        seed_we_i,
  input  logic [srg_pkg::SEED_W-1:0]  seed_i,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic [srg_pkg::FRAC_W-1:0]  fraction_o,
  output logic                        coin_o,
  output logic [PICK_BITS-1:0]        pick_o
);

  localparam int FB     = FRACTION_BITS;
  localparam int SPAN_W = PICK_BITS + 1;
  localparam int NCH    = (SPAN_W + srg_pkg::MUL_W - 1) / srg_pkg::MUL_W;
  localparam int PAD_W  = NCH * srg_pkg::MUL_W;
  localparam int PP_W   = FB + srg_pkg::MUL_W;
  localparam int ACC_W  = FB + PAD_W;
  localparam int CNT_W  = $clog2(NCH + 1);
  // Warm-up constant: 1e-9 rounded to the nearest step of the fraction.
  localparam logic [63:0] WARM_FULL =
    ((64'd1 << FB) + 64'd500000000) / 64'd1000000000;

  // Lag table and per-entry valid bits.
  logic [FB-1:0]                       mem_q [srg_pkg::TABLE_DEPTH];
  logic [srg_pkg::TABLE_DEPTH-1:0]     vld_q;
  logic [FB-1:0]                       rd_a_q, rd_b_q;
  logic                                vld_a_q, vld_b_q;
  logic [FB-1:0]                       val_a, val_b, diff, wr_data;

  // Configuration and warm-up recurrence.
  logic [srg_pkg::SEED_W-1:0]          seed_q;
  logic [FB-1:0]                       seed_scaled;
  logic [FB-1:0]                       cur_q, prev_q;

  // Latched request payload.
  logic [srg_pkg::THR_W-1:0]           thr_q;
  logic [PICK_BITS-1:0]                lo_q, hi_q;

  // Drawn entry and range multiplier.
  logic [FB-1:0]                       entry_q;
  logic [PAD_W-1:0]                    span_sr_q;
  logic [PAD_W-1:0]                    span_pad;
  logic [SPAN_W-1:0]                   span;
  logic [PP_W-1:0]                     pp_q;
  logic [ACC_W-1:0]                    acc_q;
  logic [CNT_W-1:0]                    cnt_q;

  // Result formatting and output register.
  logic [srg_pkg::FRAC_W-1:0]          frac_c;
  logic                                coin_c;
  logic [PICK_BITS-1:0]                pick_c;
  logic                                out_valid_q;

  // Entries never written since reset or reseed read as zero.
  assign val_a   = vld_a_q ? rd_a_q : '0;
  assign val_b   = vld_b_q ? rd_b_q : '0;
  assign diff    = val_a - val_b;
  assign wr_data = cmd_i.scatter ? cur_q : diff;

  // Table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    rd_a_q  <= mem_q[cmd_i.addr_a];
    rd_b_q  <= mem_q[cmd_i.addr_b];
    vld_a_q <= vld_q[cmd_i.addr_a];
    vld_b_q <= vld_q[cmd_i.addr_b];
  end

  // Valid bits, seed register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.reseed) begin
        vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        vld_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Alignment between the fraction width and the 32-bit port fields.
  generate
    if (FB >= srg_pkg::FRAC_W) begin : g_wide
      localparam int SH = FB - srg_pkg::FRAC_W;
      assign seed_scaled = FB'(seed_q) << SH;
      assign frac_c      = entry_q[FB-1 -: srg_pkg::FRAC_W];
      assign coin_c      = (FB + 1)'(entry_q) <= ((FB + 1)'(thr_q) << SH);
    end else begin : g_narrow
      localparam int SH = srg_pkg::FRAC_W - FB;
      assign seed_scaled = seed_q[srg_pkg::SEED_W-1 -: FB];
      assign frac_c      = srg_pkg::FRAC_W'(entry_q) << SH;
      assign coin_c      = (srg_pkg::THR_W'(entry_q) << SH) <= thr_q;
    end
  endgenerate

  // Range span, zero padded to whole multiplier chunks.
  assign span     = SPAN_W'(hi_q) - SPAN_W'(lo_q) + SPAN_W'(1);
  assign span_pad = PAD_W'(span);

  // Scaled pick; an empty range returns its low end.
  assign pick_c = (lo_q >= hi_q) ? lo_q : (acc_q[FB +: PICK_BITS] + lo_q);

  assign stat_o.mul_last = (cnt_q == CNT_W'(NCH));
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  // Payload registers: request latch, recurrence, multiplier, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      thr_q <= threshold_i;
      lo_q  <= range_low_i;
      hi_q  <= range_high_i;
    end
    if (cmd_i.reseed) begin
      cur_q  <= WARM_FULL[FB-1:0];
      prev_q <= seed_scaled;
    end else if (cmd_i.scatter) begin
      cur_q  <= prev_q - cur_q;
      prev_q <= cur_q;
    end
    if (cmd_i.load_entry) begin
      entry_q <= cmd_i.entry_diff ? diff : val_a;
    end
    // Top chunk first: shift the running sum up one chunk per step.
    if (cmd_i.mul_start) begin
      span_sr_q <= span_pad;
      pp_q      <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.mul_step) begin
      pp_q      <= entry_q * span_sr_q[PAD_W-1 -: srg_pkg::MUL_W];
      span_sr_q <= span_sr_q << srg_pkg::MUL_W;
      acc_q     <= (acc_q << srg_pkg::MUL_W) + ACC_W'(pp_q);
      cnt_q     <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      fraction_o <= frac_c;
      coin_o     <= coin_c;
      pick_o     <= pick_c;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ===== rtl/subtractive_random_generator.sv =====
// Top level of the subtractive lag-24/55 uniform generator.
// Depends on srg_pkg, the channel interfaces, srg_ctrl and srg_datapath.
//
// Usage:
//   req_i  carries one transaction per command: cmd 0 draws a number, cmd 1
//          rebuilds the lag table from the seed register. Threshold and the
//          range fields matter only for a draw.
//   rsp_o  returns one transaction per draw: the fraction, the coin and the
//          scaled pick. A reseed returns nothing.
//   cfg_i  writes the seed register; it is always ready and should only be
//          written while no command is in progress.
// Sequence:
//   A draw passes from acceptance through the table read, the entry load and
//   the chunked range multiply to the result register, and the next command is
//   accepted the cycle after. The draw that wraps the read index first advances
//   entry zero; the rest of the table advance is spread over the draws, one
//   entry each, through the single table write port.
//   A reseed writes 54 scatter entries, then advances all 55 entries three
//   times, each entry with a read state and a write state.
// Reset:
//   The table reads as all zero, the read index and the seed are zero.
// Stall:
//   A finished result waits in the output register; a new command is still
//   accepted, but the next draw holds in its last step until the result is taken.
`timescale 1ns / 1ps

module subtractive_random_generator #(
  parameter int FRACTION_BITS = 32,
  parameter int PICK_BITS     = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srg_req_if.sink   req_i,
  srg_rsp_if.source rsp_o,
  srg_cfg_if.sink   cfg_i
);

  srg_pkg::srg_cmd_t  cmd;
  srg_pkg::srg_stat_t stat;
  logic               req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  // Sequencer.
  srg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table, arithmetic and output register.
  srg_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .PICK_BITS     (PICK_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .threshold_i  (req_i.threshold),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .seed_we_i    (cfg_i.valid),
    .seed_i       (cfg_i.seed),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .fraction_o   (rsp_o.fraction),
    .coin_o       (rsp_o.coin),
    .pick_o       (rsp_o.pick)
  );

endmodule

// ===== sim/tb_subtractive_random_generator.sv =====
// Self-checking testbench of the subtractive lag-24/55 random generator.
// Depends on srg_pkg, the srg channel interfaces and subtractive_random_generator.
`timescale 1ns / 1ps

module tb_subtractive_random_generator;

  // Package constants used by the predictor and the stimulus.
  localparam int   FRAC_W       = srg_pkg::FRAC_W;
  localparam int   THR_W        = srg_pkg::THR_W;
  localparam int   SEED_W       = srg_pkg::SEED_W;
  localparam int   IDX_W        = srg_pkg::IDX_W;
  localparam int   TABLE_DEPTH  = srg_pkg::TABLE_DEPTH;
  localparam int   LAG_SHORT    = srg_pkg::LAG_SHORT;
  localparam int   LAG_GAP      = srg_pkg::LAG_GAP;
  localparam int   SCATTER_STEP = srg_pkg::SCATTER_STEP;
  localparam int   SCATTER_MOD  = srg_pkg::SCATTER_MOD;
  localparam int   ADV_PASSES   = srg_pkg::ADV_PASSES;
  localparam logic CMD_DRAW     = srg_pkg::CMD_DRAW;
  localparam logic CMD_RESEED   = srg_pkg::CMD_RESEED;

  localparam int PICK_W        = 16;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  // Wait that covers a reseed, which keeps the block busy and returns nothing.
  localparam int RESEED_CYCLES = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam int RESEED_PCT    = 3;
  localparam int IDLE_PCT      = 20;
  localparam int QUIET_PHASE   = 3;

  // Warm-up start value: one billionth, rounded to the nearest multiple of 2^-32.
  localparam logic [FRAC_W-1:0] WARMUP_STEP = 32'd4;
  localparam logic [THR_W-1:0]  THR_ALWAYS  = 33'h1_0000_0000;
  localparam logic [THR_W-1:0]  THR_TOP32   = 33'h0_FFFF_FFFF;
  localparam logic [PICK_W-1:0] PICK_TOP    = 16'hFFFF;

  typedef struct packed {
    logic              cmd;
    logic [THR_W-1:0]  threshold;
    logic [PICK_W-1:0] range_low;
    logic [PICK_W-1:0] range_high;
  } gen_req_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic              coin;
    logic [PICK_W-1:0] pick;
  } draw_result_t;

  typedef struct packed {
    gen_req_t     req;
    logic         typed_in;
    draw_result_t want;
  } stim_row_t;

  // Directed rows. An unseeded table is all zero, so those draws are known exactly.
  localparam stim_row_t DIRECTED_ROWS [16] = '{
    '{'{CMD_DRAW, 33'h0, 16'h0000, PICK_TOP}, 1'b1, '{32'h0, 1'b1, 16'h0000}},
    '{'{CMD_DRAW, THR_ALWAYS, PICK_TOP, 16'h0000}, 1'b1, '{32'h0, 1'b1, PICK_TOP}},
    '{'{CMD_DRAW, THR_TOP32, 16'h1234, 16'h1234}, 1'b1, '{32'h0, 1'b1, 16'h1234}},
    '{'{CMD_DRAW, 33'h0_5555_5555, 16'hFFFE, PICK_TOP}, 1'b1, '{32'h0, 1'b1, 16'hFFFE}},
    '{'{CMD_RESEED, 33'h0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{CMD_DRAW, 33'h0, 16'h0000, PICK_TOP}, 1'b0, '0},
    '{'{CMD_DRAW, THR_ALWAYS, 16'h0000, 16'h0001}, 1'b0, '0},
    '{'{CMD_DRAW, THR_TOP32, PICK_TOP, PICK_TOP}, 1'b0, '0},
    '{'{CMD_DRAW, 33'h0_8000_0000, 16'd100, 16'd99}, 1'b0, '0},
    '{'{CMD_DRAW, 33'h0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{CMD_RESEED, THR_ALWAYS, PICK_TOP, PICK_TOP}, 1'b0, '0},
    '{'{CMD_RESEED, 33'h0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{CMD_DRAW, THR_ALWAYS, 16'h0000, PICK_TOP}, 1'b0, '0},
    '{'{CMD_DRAW, 33'h0_5555_5555, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{CMD_DRAW, 33'h0_AAAA_AAAA, 16'h2AAA, 16'hD555}, 1'b0, '0},
    '{'{CMD_DRAW, THR_TOP32, 16'h0000, PICK_TOP}, 1'b0, '0}
  };

  localparam logic [SEED_W-1:0] PHASE_SEEDS [4] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  srg_req_if #(.PICK_BITS(PICK_W)) req_if ();
  srg_rsp_if #(.PICK_BITS(PICK_W)) rsp_if ();
  srg_cfg_if                       cfg_if ();

  subtractive_random_generator #(
    .FRACTION_BITS(FRAC_W),
    .PICK_BITS    (PICK_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state: the lag table, the read index and the seed register.
  logic [FRAC_W-1:0] lag_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]  draw_idx;
  logic [SEED_W-1:0] seed_reg;

  draw_result_t pending_draws [$];
  int           err_count   = 0;
  int           quiet_cycles = 0;
  int           idle_pct    = IDLE_PCT;

  // One full advance: low entries subtract their partner 31 up, the rest 24 down.
  function automatic void advance_lag_mem();
    for (int j = 0; j < LAG_SHORT; j++) begin
      lag_mem[j] = lag_mem[j] - lag_mem[j + LAG_GAP];
    end
    for (int j = LAG_SHORT; j < TABLE_DEPTH; j++) begin
      lag_mem[j] = lag_mem[j] - lag_mem[j - LAG_SHORT];
    end
  endfunction

  // Clear the table, scatter the warm-up sequence, then advance three times.
  function automatic void rebuild_lag_mem();
    logic [FRAC_W-1:0] cur;
    logic [FRAC_W-1:0] prev;
    int                slot;
    foreach (lag_mem[k]) begin
      lag_mem[k] = '0;
    end
    cur  = WARMUP_STEP;
    prev = seed_reg;
    for (int j = 1; j <= SCATTER_MOD; j++) begin
      slot          = (SCATTER_STEP * j) % SCATTER_MOD;
      lag_mem[slot] = cur;
      cur           = prev - cur;
      prev          = lag_mem[slot];
    end
    repeat (ADV_PASSES) advance_lag_mem();
    draw_idx = '0;
  endfunction

  // Applies one command to the predictor; returns 1 when it yields a draw.
  function automatic bit predict_command(input gen_req_t rq, output draw_result_t res);
    logic [FRAC_W-1:0] entry;
    logic [PICK_W:0]   span;
    logic [63:0]       prod;
    res = '0;
    if (rq.cmd == CMD_RESEED) begin
      rebuild_lag_mem();
      return 1'b0;
    end
    draw_idx = draw_idx + 1'b1;
    if (draw_idx >= TABLE_DEPTH) begin
      draw_idx = IDX_W'(1);
      advance_lag_mem();
    end
    entry        = lag_mem[draw_idx];
    res.fraction = entry;
    res.coin     = ({1'b0, entry} <= rq.threshold);
    if (rq.range_low >= rq.range_high) begin
      res.pick = rq.range_low;
    end else begin
      span     = {1'b0, rq.range_high} - {1'b0, rq.range_low} + 1'b1;
      prod     = 64'(entry) * 64'(span);
      res.pick = prod[FRAC_W +: PICK_W] + rq.range_low;
    end
    return 1'b1;
  endfunction

  function automatic gen_req_t random_request();
    gen_req_t rq;
    rq.cmd = ($urandom_range(99) < RESEED_PCT) ? CMD_RESEED : CMD_DRAW;
    case ($urandom_range(9))
      0: begin
        rq.threshold = THR_ALWAYS;
      end
      1: begin
        rq.threshold = '0;
      end
      2: begin
        rq.threshold = THR_TOP32;
      end
      default: begin
        rq.threshold = {1'b0, $urandom()};
      end
    endcase
    case ($urandom_range(5))
      0: begin
        rq.range_low  = '0;
        rq.range_high = PICK_TOP;
      end
      1: begin
        rq.range_low  = PICK_W'($urandom());
        rq.range_high = rq.range_low;
      end
      2: begin
        rq.range_low  = PICK_W'($urandom_range(65000));
        rq.range_high = rq.range_low + PICK_W'($urandom_range(30, 1));
      end
      default: begin
        rq.range_low  = PICK_W'($urandom());
        rq.range_high = PICK_W'($urandom());
      end
    endcase
    return rq;
  endfunction

  // Presents one command, waits for its transaction and records the expectation.
  task automatic drive_request(input gen_req_t rq, input logic typed_in,
                               input draw_result_t want);
    int           gap;
    draw_result_t res;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= rq.cmd;
    req_if.threshold  <= rq.threshold;
    req_if.range_low  <= rq.range_low;
    req_if.range_high <= rq.range_high;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (predict_command(rq, res)) begin
      pending_draws.push_back(typed_in ? want : res);
    end
  endtask

  // Lets the block drain: all draws returned, then time for a trailing reseed.
  task automatic drain_block();
    req_if.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (RESEED_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] value);
    drain_block();
    cfg_if.valid <= 1'b1;
    cfg_if.seed  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    seed_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_draw(input logic [FRAC_W-1:0] fraction, input logic coin,
                            input logic [PICK_W-1:0] pick);
    draw_result_t exp_draw;
    if (pending_draws.size() == 0) begin
      $error("unexpected draw transaction: fraction %h coin %b pick %0d",
             fraction, coin, pick);
      err_count++;
    end else begin
      exp_draw = pending_draws.pop_front();
      if (fraction !== exp_draw.fraction) begin
        $error("fraction: expected %h, actual %h", exp_draw.fraction, fraction);
        err_count++;
      end
      if (coin !== exp_draw.coin) begin
        $error("coin: expected %b, actual %b", exp_draw.coin, coin);
        err_count++;
      end
      if (pick !== exp_draw.pick) begin
        $error("pick: expected %0d, actual %0d", exp_draw.pick, pick);
        err_count++;
      end
    end
  endtask

  // Response side: check each accepted draw and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      check_draw(rsp_if.fraction, rsp_if.coin, rsp_if.pick);
    end
    rsp_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed rows, then phases of random commands under new seeds.
  initial begin
    logic [SEED_W-1:0] phase_seed;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_DRAW;
    req_if.threshold  <= '0;
    req_if.range_low  <= '0;
    req_if.range_high <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.seed       <= '0;
    foreach (lag_mem[k]) begin
      lag_mem[k] = '0;
    end
    draw_idx = '0;
    seed_reg = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      drive_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      phase_seed = (p < 4) ? PHASE_SEEDS[p] : $urandom();
      write_seed(phase_seed);
      // One phase runs with no idling on either side.
      idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
      drive_request('{CMD_RESEED, '0, '0, '0}, 1'b0, '0);
      repeat (PHASE_ITEMS - 1) drive_request(random_request(), 1'b0, '0);
    end

    drain_block();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srg_pkg.sv
rtl/srg_if.sv
rtl/srg_ctrl.sv
rtl/srg_datapath.sv
rtl/subtractive_random_generator.sv
sim/tb_subtractive_random_generator.sv
